>>> design/x86e_pkg.sv
package x86e_pkg;

   localparam int MaxBytes = 10;
   localparam int CountWidth = 4;

   typedef logic [7:0] byte_type;
   typedef byte_type [MaxBytes-1:0] code_type;

   typedef struct packed {
      code_type             code;
      logic [CountWidth-1:0] count;
   } encoding_type;

   localparam logic [7:0] OpImm8 = 8'h83;
   localparam logic [7:0] OpImm32 = 8'h81;
   localparam logic [7:0] OpEscape = 8'h0F;
   localparam logic [7:0] OpImul = 8'hAF;
   localparam logic [7:0] OpMovImm = 8'hB8;
   localparam logic [7:0] OpRex = 8'h40;
   localparam logic [7:0] OpSetcc = 8'h90;
   localparam logic [7:0] OpJcc = 8'h80;
   localparam logic [7:0] PfxF2 = 8'hF2;
   localparam logic [7:0] Pfx66 = 8'h66;
   localparam logic [7:0] OpJmp = 8'hE9;
   localparam logic [7:0] OpRet = 8'hC3;

endpackage

>>> design/x86e_encode.sv
module x86e_encode (
   input  logic [5:0]  mode,
   input  logic [3:0]  first_reg,
   input  logic [3:0]  second_reg,
   input  logic [3:0]  base_reg,
   input  logic [3:0]  cond_code,
   input  logic [63:0] immediate,
   input  logic [31:0] displacement,
   output x86e_pkg::encoding_type enc
);

   x86e_pkg::code_type c;
   logic [3:0] n;
   logic [3:0] a, s, mr, mb;
   logic [31:0] i32, hi32, d;
   logic fit_i, fit_d;
   logic [2:0] lo;
   logic [1:0] mmod;
   logic [7:0] op, ext, pfx, rexb;
   logic w, sib, rex_need;

   function automatic logic [7:0] rex_f(logic w1, logic [3:0] r, logic [3:0] b);
      rex_f = x86e_pkg::OpRex | {4'd0, w1, r[3], 1'b0, b[3]};
   endfunction

   function automatic logic [7:0] modrm_f(logic [1:0] md, logic [2:0] rg,
         logic [2:0] rm);
      modrm_f = {md, rg, rm};
   endfunction

   always_comb begin
      a = first_reg;
      s = second_reg;
      i32 = immediate[31:0];
      hi32 = immediate[63:32];
      d = displacement;
      fit_i = (i32 + 32'h80) < 32'h100;
      fit_d = (d + 32'h80) < 32'h100;
      lo = base_reg[2:0];
      mmod = (d == 32'd0 && lo != 3'd5) ? 2'd0 : (fit_d ? 2'd1 : 2'd2);
      sib = (lo == 3'd4);
      c = '0;
      n = '0;
      op = '0;
      ext = '0;
      pfx = '0;
      w = 1'b0;
      mr = a;
      mb = base_reg;
      rexb = '0;
      rex_need = 1'b0;
      // opcode byte for each mode (ALU, move, memory and SSE forms)
      unique case (mode)
         6'd0: op = 8'h01;
         6'd2: op = 8'h29;
         6'd8: op = 8'h21;
         6'd9: op = 8'h09;
         6'd10: op = 8'h31;
         6'd15: op = 8'h39;
         6'd17: op = 8'h85;
         6'd18: op = 8'h89;
         6'd21: op = 8'h8B;
         6'd22: op = 8'h89;
         6'd23: op = 8'h8D;
         6'd24: op = 8'h63;
         6'd36: op = 8'h58;
         6'd37: op = 8'h5C;
         6'd38: op = 8'h59;
         6'd39: op = 8'h5E;
         6'd40: op = 8'h10;
         6'd41: op = 8'h10;
         6'd42: op = 8'h11;
         6'd43: op = 8'h2A;
         6'd44: op = 8'h2C;
         6'd45: op = 8'h2E;
         6'd46: op = 8'h6E;
         6'd47: op = 8'h7E;
         6'd48: op = 8'h57;
         6'd5, 6'd7, 6'd11: op = 8'hF7;
         default: op = 8'hD3;
      endcase
      unique case (mode)
         6'd1: ext = 8'd0;
         6'd3: ext = 8'd5;
         6'd5: ext = 8'd3;
         6'd7: ext = 8'd7;
         6'd11: ext = 8'd2;
         6'd12: ext = 8'd4;
         6'd13: ext = 8'd5;
         6'd14: ext = 8'd7;
         default: ext = 8'd7;
      endcase
      unique case (mode)
         6'd0, 6'd2, 6'd8, 6'd9, 6'd10, 6'd15, 6'd17, 6'd18: begin
            c[0] = rex_f(1'b1, s, a);
            c[1] = op;
            c[2] = modrm_f(2'd3, s[2:0], a[2:0]);
            n = 4'd3;
         end
         6'd1, 6'd3, 6'd16: begin
            c[0] = rex_f(1'b1, 4'd0, a);
            c[2] = modrm_f(2'd3, ext[2:0], a[2:0]);
            if (fit_i) begin
               c[1] = x86e_pkg::OpImm8;
               c[3] = i32[7:0];
               n = 4'd4;
            end else begin
               c[1] = x86e_pkg::OpImm32;
               {c[6], c[5], c[4], c[3]} = i32;
               n = 4'd7;
            end
         end
         6'd4, 6'd25: begin
            c[0] = rex_f(1'b1, a, s);
            c[1] = x86e_pkg::OpEscape;
            c[2] = (mode == 6'd4) ? x86e_pkg::OpImul : x86e_pkg::OpRex + {4'd0, cond_code};
            c[3] = modrm_f(2'd3, a[2:0], s[2:0]);
            n = 4'd4;
         end
         6'd5, 6'd7, 6'd11, 6'd12, 6'd13, 6'd14: begin
            c[0] = rex_f(1'b1, 4'd0, a);
            c[1] = op;
            c[2] = modrm_f(2'd3, ext[2:0], a[2:0]);
            n = 4'd3;
         end
         6'd6: begin
            c[0] = rex_f(1'b1, 4'd0, 4'd0);
            c[1] = 8'h99;
            n = 4'd2;
         end
         6'd19: begin
            c[0] = rex_f(1'b1, 4'd0, a);
            c[1] = x86e_pkg::OpMovImm + {5'd0, a[2:0]};
            {c[5], c[4], c[3], c[2]} = i32;
            {c[9], c[8], c[7], c[6]} = hi32;
            n = 4'd10;
         end
         6'd20: begin
            if (a[3]) begin
               c[0] = rex_f(1'b0, 4'd0, a);
               c[1] = x86e_pkg::OpMovImm + {5'd0, a[2:0]};
               {c[5], c[4], c[3], c[2]} = i32;
               n = 4'd6;
            end else begin
               c[0] = x86e_pkg::OpMovImm + {5'd0, a[2:0]};
               {c[4], c[3], c[2], c[1]} = i32;
               n = 4'd5;
            end
         end
         6'd21, 6'd22, 6'd23, 6'd24, 6'd41, 6'd42: begin
            mr = (mode == 6'd22 || mode == 6'd42) ? s : a;
            // prefix and opcode bytes, then ModRM at position n
            if (mode == 6'd41 || mode == 6'd42) begin
               c[0] = x86e_pkg::PfxF2;
               if (mr[3] || mb[3]) begin
                  c[1] = rex_f(1'b0, mr, mb);
                  c[2] = x86e_pkg::OpEscape;
                  c[3] = op;
                  n = 4'd4;
               end else begin
                  c[1] = x86e_pkg::OpEscape;
                  c[2] = op;
                  n = 4'd3;
               end
            end else begin
               c[0] = rex_f(1'b1, mr, mb);
               c[1] = op;
               n = 4'd2;
            end
            c[n] = modrm_f(mmod, mr[2:0], lo);
            n = n + 4'd1;
            if (sib) begin
               c[n] = 8'h24;
               n = n + 4'd1;
            end
            if (mmod == 2'd1) begin
               c[n] = d[7:0];
               n = n + 4'd1;
            end else if (mmod == 2'd2) begin
               c[n] = d[7:0];
               c[n+4'd1] = d[15:8];
               c[n+4'd2] = d[23:16];
               c[n+4'd3] = d[31:24];
               n = n + 4'd4;
            end
         end
         6'd26: begin
            if (a >= 4'd4) begin
               c[0] = rex_f(1'b0, 4'd0, a);
               c[1] = x86e_pkg::OpEscape;
               c[2] = x86e_pkg::OpSetcc + {4'd0, cond_code};
               c[3] = modrm_f(2'd3, 3'd0, a[2:0]);
               n = 4'd4;
            end else begin
               c[0] = x86e_pkg::OpEscape;
               c[1] = x86e_pkg::OpSetcc + {4'd0, cond_code};
               c[2] = modrm_f(2'd3, 3'd0, a[2:0]);
               n = 4'd3;
            end
         end
         6'd27, 6'd30: begin
            c[0] = (mode == 6'd27) ? x86e_pkg::OpJmp : 8'hE8;
            {c[4], c[3], c[2], c[1]} = i32;
            n = 4'd5;
         end
         6'd28: begin
            c[0] = 8'hEB;
            c[1] = i32[7:0];
            n = 4'd2;
         end
         6'd29: begin
            c[0] = x86e_pkg::OpEscape;
            c[1] = x86e_pkg::OpJcc + {4'd0, cond_code};
            {c[5], c[4], c[3], c[2]} = i32;
            n = 4'd6;
         end
         6'd31: begin
            if (a[3]) begin
               c[0] = rex_f(1'b0, 4'd0, a);
               c[1] = 8'hFF;
               c[2] = modrm_f(2'd3, 3'd2, a[2:0]);
               n = 4'd3;
            end else begin
               c[0] = 8'hFF;
               c[1] = modrm_f(2'd3, 3'd2, a[2:0]);
               n = 4'd2;
            end
         end
         6'd32: begin
            c[0] = x86e_pkg::OpRet;
            n = 4'd1;
         end
         6'd33: begin
            c[0] = 8'h90;
            n = 4'd1;
         end
         6'd34, 6'd35: begin
            op = (mode == 6'd34) ? 8'h50 : 8'h58;
            if (a[3]) begin
               c[0] = rex_f(1'b0, 4'd0, a);
               c[1] = op + {5'd0, a[2:0]};
               n = 4'd2;
            end else begin
               c[0] = op + {5'd0, a[2:0]};
               n = 4'd1;
            end
         end
         6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd45, 6'd48,
         6'd43, 6'd44, 6'd46, 6'd47: begin
            pfx = (mode == 6'd45 || mode == 6'd46 || mode == 6'd47 || mode == 6'd48)
               ? x86e_pkg::Pfx66 : x86e_pkg::PfxF2;
            w = (mode == 6'd43 || mode == 6'd44 || mode == 6'd46 || mode == 6'd47);
            mr = (mode == 6'd47) ? s : a;
            mb = (mode == 6'd47) ? a : s;
            rex_need = w || mr[3] || mb[3];
            rexb = rex_f(w, mr, mb);
            c[0] = pfx;
            if (rex_need) begin
               c[1] = rexb;
               c[2] = x86e_pkg::OpEscape;
               c[3] = op;
               c[4] = modrm_f(2'd3, mr[2:0], mb[2:0]);
               n = 4'd5;
            end else begin
               c[1] = x86e_pkg::OpEscape;
               c[2] = op;
               c[3] = modrm_f(2'd3, mr[2:0], mb[2:0]);
               n = 4'd4;
            end
         end
         default: n = 4'd0;
      endcase
      enc.code = c;
      enc.count = n;
   end

endmodule

>>> design/x86_64_instruction_encoder_core.sv
// Instruction encoder: each request is encoded in the cycle it is accepted and
// its bytes (up to ten) are registered; they then leave on the response channel
// one per cycle while rsp_stall is low, the final one flagged by rsp_last_byte.
// Instructions are 1 to 10 bytes long; the next request is taken as the last
// byte of the current one leaves, so the byte serialiser sets the rate. Unused
// modes (49 to 63) produce no response.
module x86_64_instruction_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [5:0]  req_mode,
   input  logic [3:0]  req_first_reg,
   input  logic [3:0]  req_second_reg,
   input  logic [3:0]  req_base_reg,
   input  logic [3:0]  req_cond_code,
   input  logic [63:0] req_immediate,
   input  logic signed [31:0] req_displacement,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_code_byte,
   output logic        rsp_last_byte
);

   x86e_pkg::encoding_type enc, buf_ff, buf_in;
   logic [3:0] idx_ff, idx_in;
   logic busy_ff, busy_in;
   logic take, done;

   x86e_encode u_enc (
      .mode(req_mode), .first_reg(req_first_reg), .second_reg(req_second_reg),
      .base_reg(req_base_reg), .cond_code(req_cond_code),
      .immediate(req_immediate), .displacement(req_displacement), .enc(enc)
   );

   assign done = busy_ff && !rsp_stall && (idx_ff == buf_ff.count - 4'd1);
   assign req_stall = busy_ff && !done;
   assign take = req_valid && !req_stall;
   assign rsp_valid = busy_ff;
   assign rsp_code_byte = buf_ff.code[idx_ff];
   assign rsp_last_byte = (idx_ff == buf_ff.count - 4'd1);

   always_comb begin
      buf_in = buf_ff;
      idx_in = idx_ff;
      busy_in = busy_ff;
      if (busy_ff && !rsp_stall) begin
         idx_in = idx_ff + 4'd1;
         if (done) busy_in = 1'b0;
      end
      if (take) begin
         buf_in = enc;
         idx_in = '0;
         busy_in = (enc.count != 4'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff <= idx_in;
      end
      buf_ff <= buf_in;
   end

endmodule
